FILE: sv/mdd_pkg.sv
package mdd_pkg;

  localparam int unsigned DBT_W   = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IN_W    = 40;  // 37 bits of fields, padded to 5 bytes
  localparam int unsigned OUT_W   = 40;
  localparam logic [DBT_W-1:0]  DBT_RESET   = DBT_W'(50);
  localparam logic [TIME_W-1:0] WAIT_FOREVER = '1;

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_IRQ     = 3'd1,
    CMD_MANUAL  = 3'd2,
    CMD_PROCESS = 3'd3,
    CMD_POLL    = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_DEINIT  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IO        = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_INSERTED = 2'd1,
    EV_REMOVED  = 2'd2,
    EV_ERROR    = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    M_ERROR   = 3'd0,
    M_ABSENT  = 3'd1,
    M_PRESENT = 3'd2,
    M_DEB_INS = 3'd3,
    M_DEB_REM = 3'd4
  } mode_e;

  typedef enum logic {
    CFG_DEBOUNCE_TIME = 1'b0,
    CFG_ACTIVE_HIGH   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] now_ms;
    logic              pin_level;
    logic              read_error;
  } item_t;

  typedef struct packed {
    status_e           status;
    event_e            event_res;
    mode_e             media_state;
    logic              media_present;
    logic [TIME_W-1:0] wait_ms;
  } result_t;

  typedef struct packed {
    mode_e             mode;
    logic              stable_level;
    logic              candidate_level;
    logic              debounce_active;
    logic [TIME_W-1:0] deadline_ms;
    logic              check_pending;
    logic              last_raw_level;
    logic              inited;
    logic              accepting;
  } state_t;

endpackage

FILE: sv/mdd_core.sv
module mdd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [30:0]          cfg_data,
  input  logic                 step,
  input  mdd_pkg::item_t       item,
  output mdd_pkg::result_t     res
);
  import mdd_pkg::*;

  logic [DBT_W-1:0] debounce_time;
  logic             active_high;
  state_t           st;
  state_t           st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DBT_RESET;
      active_high   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_DEBOUNCE_TIME: debounce_time <= cfg_data;
        CFG_ACTIVE_HIGH:   active_high   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: M_ERROR, deadline_ms: '0, default: 1'b0};
    end else if (step) begin
      st <= st_next;
    end
  end

  logic [TIME_W-1:0] dbt_ext;
  logic              present;
  logic              rerr;
  logic              raw;
  logic [TIME_W-1:0] now;

  assign dbt_ext = {1'b0, debounce_time};
  assign raw     = item.pin_level;
  assign rerr    = item.read_error;
  assign now     = item.now_ms;
  assign present = active_high ? raw : ~raw;

  always_comb begin
    state_t            s;
    status_e           status;
    event_e            ev;
    logic [TIME_W-1:0] wait_v;
    logic [TIME_W-1:0] since;
    logic              ready;
    logic              do_proc;
    logic              errored;

    s       = st;
    status  = ST_OK;
    ev      = EV_NONE;
    wait_v  = WAIT_FOREVER;
    ready   = st.inited & st.accepting;
    do_proc = 1'b0;
    errored = 1'b0;
    since   = '0;

    unique case (cmd_e'(item.command))
      CMD_INIT: begin
        s = '{mode: M_ERROR, deadline_ms: '0, default: 1'b0};
        s.inited    = 1'b1;
        s.accepting = 1'b1;
        if (rerr) begin
          status = ST_IO;  // already in error: no event
        end else begin
          s.stable_level    = present;
          s.candidate_level = present;
          s.last_raw_level  = raw;
          s.mode            = present ? M_PRESENT : M_ABSENT;
        end
      end
      CMD_IRQ: begin
        if (!ready) status = ST_NOT_READY;
        else        s.check_pending = 1'b1;
      end
      CMD_MANUAL: begin
        if (!ready) begin
          status = ST_NOT_READY;
        end else if (rerr) begin
          if (s.mode != M_ERROR) ev = EV_ERROR;
          s.mode = M_ERROR;
          s.debounce_active = 1'b0;
          status = ST_IO;
        end else begin
          s.check_pending = 1'b1;
        end
      end
      CMD_PROCESS: do_proc = 1'b1;
      CMD_POLL: begin
        if (!ready) begin
          status = ST_NOT_READY;
        end else if (rerr) begin
          if (s.mode != M_ERROR) ev = EV_ERROR;
          s.mode = M_ERROR;
          s.debounce_active = 1'b0;
          status = ST_IO;
        end else begin
          if (raw != s.last_raw_level) begin
            s.last_raw_level = raw;
            s.check_pending  = 1'b1;
          end
          do_proc = 1'b1;
        end
      end
      CMD_STOP: begin
        if (!st.inited) status = ST_NOT_READY;
        else            s.accepting = 1'b0;
      end
      CMD_DEINIT: begin
        if (!st.inited) begin
          status = ST_NOT_READY;
        end else begin
          s.inited          = 1'b0;
          s.accepting       = 1'b0;
          s.debounce_active = 1'b0;
        end
      end
      default: status = ST_NOT_READY;
    endcase

    // Debounce step shared by process and poll.
    if (do_proc) begin
      if (!s.inited) begin
        status = ST_NOT_READY;
      end else begin
        if (s.check_pending) begin
          if (rerr) begin
            if (s.mode != M_ERROR) ev = EV_ERROR;
            s.mode = M_ERROR;
            s.debounce_active = 1'b0;
            status  = ST_IO;
            errored = 1'b1;
          end else begin
            s.last_raw_level  = raw;
            s.check_pending   = 1'b0;
            s.candidate_level = present;
            s.mode            = present ? M_DEB_INS : M_DEB_REM;
            s.deadline_ms     = now + dbt_ext;
            s.debounce_active = 1'b1;
          end
        end
        since = now - s.deadline_ms;
        if (!errored && s.debounce_active) begin
          if (since[TIME_W-1]) begin
            wait_v = s.deadline_ms - now;
          end else if (rerr) begin
            if (s.mode != M_ERROR) ev = EV_ERROR;
            s.mode = M_ERROR;
            s.debounce_active = 1'b0;
            status = ST_IO;
          end else begin
            s.last_raw_level = raw;
            if (present != s.candidate_level) begin
              // level moved during the window: restart
              s.candidate_level = present;
              s.mode            = present ? M_DEB_INS : M_DEB_REM;
              s.deadline_ms     = now + dbt_ext;
              s.debounce_active = 1'b1;
              wait_v            = dbt_ext;
            end else begin
              if (present != s.stable_level) ev = present ? EV_INSERTED : EV_REMOVED;
              s.stable_level    = present;
              s.mode            = present ? M_PRESENT : M_ABSENT;
              s.debounce_active = 1'b0;
            end
          end
        end
      end
    end

    st_next           = s;
    res.status        = status;
    res.event_res     = ev;
    res.media_state   = s.inited ? s.mode : M_ERROR;
    res.media_present = s.inited && (s.mode == M_PRESENT);
    res.wait_ms       = wait_v;
  end

  a_deb_mode: assert property (@(posedge clk) disable iff (rst)
    st.debounce_active |-> (st.mode == M_DEB_INS || st.mode == M_DEB_REM))
    else $error("debounce running outside a debouncing mode");

  a_accept_init: assert property (@(posedge clk) disable iff (rst)
    st.accepting |-> st.inited)
    else $error("accepting notifications while not initialized");

  a_err_status: assert property (@(posedge clk) disable iff (rst)
    (step && res.event_res == EV_ERROR) |-> (res.status == ST_IO))
    else $error("error event without io status");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!st.inited && !st.check_pending))
    else $error("reset left block initialized");

endmodule

FILE: sv/mdd_out_reg.sv
module mdd_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  mdd_pkg::result_t           res,
  output logic                       free,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mdd_pkg::OUT_W-1:0]  m_tdata
);
  import mdd_pkg::*;

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.wait_ms, held.media_present, held.media_state,
                    held.event_res, held.status};

endmodule

FILE: sv/media_detect_debouncer.sv
// Channel  | Dir | Ports                                   | Content
// s_axis   | in  | s_tvalid s_tready s_tdata[39:0]         | command, time, pin, read error
// m_axis   | out | m_tvalid m_tready m_tdata[39:0]         | status, event, state, wait
// cfg      | in  | cfg_valid cfg_ready cfg_index cfg_data  | 0 debounce ms, 1 active high
//
// One item per cycle while m_tready is high; m_tvalid follows input reg, result reg.
// Stage 1 is the input register; the debounce step (one 32-bit add, two subtracts,
// sign test) runs between it and the result register, updating state in the same edge.
// rst (sync, high) clears all control state: not initialized, mode error, 50 ms, active low.
// Stalls: m_tready low holds the result register and the input register; s_tready
// drops only when both are full. cfg_ready is always high.
module media_detect_debouncer (
  input  logic                       clk,
  input  logic                       rst,
  // [2:0] command, [34:3] now_ms, [35] pin_level, [36] read_error, [39:37] zero
  input  logic [mdd_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [1:0] status, [3:2] event_res, [6:4] media_state, [7] media_present, [39:8] wait_ms
  output logic [mdd_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [30:0]                cfg_data
);
  import mdd_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    free;
  logic    step;
  result_t res;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && free;
  assign s_tready  = !in_valid || free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.command    <= s_tdata[2:0];
      in_item.now_ms     <= s_tdata[34:3];
      in_item.pin_level  <= s_tdata[35];
      in_item.read_error <= s_tdata[36];
    end
  end

  mdd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (in_item),
    .res       (res)
  );

  mdd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (in_valid),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
